/* src/cff_pkg.sv */
`timescale 1ns / 1ps
package cff_pkg;

  // CORDIC depth and kept angle resolution
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;

  // datapath widths
  localparam int CW       = 34;   // CORDIC x, y, z (signed)
  localparam int DIV_BITS = 31;   // quotient bits of the sinc divider
  localparam int REM_W    = 96;   // divider remainder

  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032875);
  localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [63:0] SMALL_U    = 64'h0000_0000_1000_0000;
  localparam logic [22:0] RECIP6     = 23'd5592406;   // ceil(2^25 / 6)

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_Q_THRESHOLD     = 3'd0,
    CFG_Q_MAGNITUDE     = 3'd1,
    CFG_ETA_CORE        = 3'd2,
    CFG_ETA_SHELL       = 3'd3,
    CFG_ETA_SOLVENT     = 3'd4,
    CFG_CORE_EDGE       = 3'd5,
    CFG_SHELL_THICKNESS = 3'd6,
    CFG_SHELL_MODE      = 3'd7
  } cfg_idx_t;

  // one CORDIC cell's contents; u rides along for the sinc divider
  typedef struct packed {
    logic                 vld;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [63:0]          u;
  } cdc_t;

  // one divider cell's contents
  typedef struct packed {
    logic                vld;
    logic                neg;
    logic                clamp;
    logic                near_zero;
    logic [21:0]         sml;
    logic [DIV_BITS-1:0] quo;
    logic [REM_W-1:0]    rem;
    logic [63:0]         u;
  } dvs_t;

  // one amplitude cell's contents
  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             sat;
    logic [63:0]      a;
    logic [2:0][30:0] smag;
    logic [2:0]       sneg;
  } amp_t;

  // arctangent of 2^-i in turn units (2^32 = one turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // quantize a turn phase, fold the left half plane and load the first cell
  function automatic cdc_t cordic_prep(input logic vld, input logic [31:0] p,
                                       input logic [63:0] u);
    cdc_t        c;
    logic [31:0] qp;
    logic [31:0] pf;
    qp     = p & ANGLE_MASK;
    c.vld  = vld;
    c.flip = qp[31] ^ qp[30];
    pf     = c.flip ? (qp ^ 32'h8000_0000) : qp;
    c.x    = CORDIC_X0;
    c.y    = '0;
    c.z    = {{(CW-32){pf[31]}}, pf};
    c.u    = u;
    return c;
  endfunction

  // magnitude of a CORDIC word
  function automatic logic [CW-1:0] cmag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

endpackage

/* src/cff_cordic_cell.sv */
`timescale 1ns / 1ps
module cff_cordic_cell
  import cff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [4:0] idx,
  input  cdc_t       cin,
  output cdc_t       cout
);

  cdc_t                 cell_nxt;
  cdc_t                 cell_r;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] at;

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    xs       = cin.x >>> idx;
    ys       = cin.y >>> idx;
    at       = CW'(atan_turn(idx));
    cell_nxt = cin;
    if (!cin.z[CW-1]) begin
      cell_nxt.x = cin.x - ys;
      cell_nxt.y = cin.y + xs;
      cell_nxt.z = cin.z - at;
    end else begin
      cell_nxt.x = cin.x + ys;
      cell_nxt.y = cin.y - xs;
      cell_nxt.z = cin.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

/* src/cff_div_cell.sv */
`timescale 1ns / 1ps
module cff_div_cell
  import cff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  dvs_t din,
  output dvs_t dout
);

  dvs_t             cell_nxt;
  dvs_t             cell_r;
  logic [REM_W-1:0] dv;

  // one restoring step against u scaled to the top quotient bit
  always_comb begin
    dv       = REM_W'({din.u, {(DIV_BITS-1){1'b0}}});
    cell_nxt = din;
    if (din.rem >= dv) begin
      cell_nxt.rem = (din.rem - dv) << 1;
      cell_nxt.quo = {din.quo[DIV_BITS-2:0], 1'b1};
    end else begin
      cell_nxt.rem = din.rem << 1;
      cell_nxt.quo = {din.quo[DIV_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign dout = cell_r;

endmodule

/* src/cff_sinc.sv */
`timescale 1ns / 1ps
module cff_sinc
  import cff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] u_in,
  output logic        out_vld,
  output logic [30:0] smag,
  output logic        sneg
);

  cdc_t        cc [CORDIC_STAGES+1];
  dvs_t        dd [DIV_BITS+1];
  cdc_t        prep_nxt;
  cdc_t        prep_r;
  dvs_t        d0_nxt;
  dvs_t        d0_r;
  logic [61:0] ph_p;
  logic [61:0] pl_p;
  logic [31:0] phase;

  // phase of u / (2 pi) in turns, then the first CORDIC cell
  always_comb begin
    ph_p     = u_in[63:32] * INV_TWO_PI;
    pl_p     = u_in[31:0] * INV_TWO_PI;
    phase    = ph_p[31:0] + {2'b00, pl_p[61:32]};
    prep_nxt = cordic_prep(in_vld, phase, u_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign cc[0] = prep_r;

  // rotation chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    cff_cordic_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .idx  (5'(i)),
      .cin  (cc[i]),
      .cout (cc[i+1])
    );
  end

  // divider setup: |sin| << 32 over u, plus the small-argument square
  logic signed [CW-1:0] yf;
  logic [CW-1:0]        ym;
  logic [51:0]          sq;
  cdc_t                 ce;

  always_comb begin
    ce               = cc[CORDIC_STAGES];
    yf               = ce.flip ? -ce.y : ce.y;
    ym               = cmag(yf);
    sq               = ce.u[27:2] * ce.u[27:2];
    d0_nxt.vld       = ce.vld;
    d0_nxt.neg       = yf[CW-1];
    d0_nxt.clamp     = 64'({ym, 1'b0}) >= ce.u;
    d0_nxt.near_zero = ce.u < SMALL_U;
    d0_nxt.sml       = sq[51:30];
    d0_nxt.quo       = '0;
    d0_nxt.rem       = REM_W'({ym, 32'h0000_0000});
    d0_nxt.u         = ce.u;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_r.vld <= 1'b0;
    end else if (en) begin
      d0_r <= d0_nxt;
    end
  end

  assign dd[0] = d0_r;

  // quotient chain, one bit per cell
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    cff_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .din  (dd[j]),
      .dout (dd[j+1])
    );
  end

  // final select: series value near zero, else clamped quotient
  dvs_t        de;
  logic [44:0] dq;
  logic [30:0] qt;
  logic [30:0] mag_nxt;
  logic        neg_nxt;
  logic        vld_r;
  logic [30:0] mag_r;
  logic        neg_r;

  always_comb begin
    de = dd[DIV_BITS];
    dq = de.sml * RECIP6;
    qt = (de.clamp || (de.quo > ONE_Q30)) ? ONE_Q30 : de.quo;
    if (de.near_zero) begin
      mag_nxt = ONE_Q30 - 31'(dq[44:25]);
      neg_nxt = 1'b0;
    end else begin
      mag_nxt = qt;
      neg_nxt = de.neg && (qt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= de.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign smag    = mag_r;
  assign sneg    = neg_r;

endmodule

/* src/cff_mul_cell.sv */
`timescale 1ns / 1ps
module cff_mul_cell
  import cff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  amp_t        ain,
  input  logic [32:0] b,
  input  logic        sh30,
  input  logic        bypass,
  input  logic        bneg,
  output amp_t        aout
);

  amp_t        mid_r;
  amp_t        out_nxt;
  amp_t        out_r;
  logic [63:0] p0_r;
  logic [63:0] p1_r;
  logic        bh_r;
  logic        sh30_r;
  logic        byp_r;
  logic        bneg_r;
  logic [97:0] full;
  logic [97:0] res;

  // stage 1: two 32x32 partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.vld <= 1'b0;
    end else if (en) begin
      mid_r <= ain;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= ain.a[31:0] * b[31:0];
      p1_r   <= ain.a[63:32] * b[31:0];
      bh_r   <= b[32];
      sh30_r <= sh30;
      byp_r  <= bypass;
      bneg_r <= bneg;
    end
  end

  // stage 2: sum, scale, saturate, unless bypassed
  always_comb begin
    full = 98'(p0_r) + {2'b00, p1_r, 32'h0000_0000}
         + (bh_r ? {2'b00, mid_r.a, 32'h0000_0000} : 98'd0);
    res  = sh30_r ? (full >> 30) : (full >> 16);
    out_nxt = mid_r;
    if (!byp_r) begin
      if (res[97:64] != '0) begin
        out_nxt.a   = '1;
        out_nxt.sat = 1'b1;
      end else begin
        out_nxt.a = res[63:0];
      end
      out_nxt.neg = mid_r.neg ^ bneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign aout = out_r;

endmodule

/* src/cube_form_factor_squared.sv */
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in      | request   | in_valid, in_ready, in_polar_angle, in_azimuth_angle
// out     | result    | out_valid, out_ready, out_amplitude_squared, out_saturated
// cfg     | write     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One request per cycle while the pipeline is not held; the pipeline depth is
// set by the two CORDIC chains and the sinc divider chain.
// The whole pipeline advances together; it holds only while a result sits
// in the output register and out_ready is low.
// Reset clears the valid bits and the configuration registers; cfg_ready
// is always high.
module cube_form_factor_squared
  import cff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_polar_angle,
  input  logic [15:0] in_azimuth_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_amplitude_squared,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic en;

  // configuration registers
  logic [31:0] q_threshold_r;
  logic [31:0] q_magnitude_r;
  logic [31:0] eta_core_r;
  logic [31:0] eta_shell_r;
  logic [31:0] eta_solvent_r;
  logic [31:0] core_edge_r;
  logic [31:0] shell_thickness_r;
  logic        shell_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_threshold_r     <= '0;
      q_magnitude_r     <= '0;
      eta_core_r        <= '0;
      eta_shell_r       <= '0;
      eta_solvent_r     <= '0;
      core_edge_r       <= '0;
      shell_thickness_r <= '0;
      shell_mode_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_Q_THRESHOLD:     q_threshold_r     <= cfg_data;
        CFG_Q_MAGNITUDE:     q_magnitude_r     <= cfg_data;
        CFG_ETA_CORE:        eta_core_r        <= cfg_data;
        CFG_ETA_SHELL:       eta_shell_r       <= cfg_data;
        CFG_ETA_SOLVENT:     eta_solvent_r     <= cfg_data;
        CFG_CORE_EDGE:       core_edge_r       <= cfg_data;
        CFG_SHELL_THICKNESS: shell_thickness_r <= cfg_data;
        CFG_SHELL_MODE:      shell_mode_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // derived settings; the user must keep them static while requests are in flight, the block does not enforce it
  logic              plain;
  logic [32:0]       edge_core;
  logic [32:0]       edge_shell;
  logic signed [32:0] d_core;
  logic signed [32:0] d_shell;

  always_comb begin
    plain      = q_magnitude_r < q_threshold_r;
    edge_core  = {1'b0, core_edge_r};
    edge_shell = {1'b0, core_edge_r} + {1'b0, shell_thickness_r};
    d_core     = {eta_core_r[31], eta_core_r} - {eta_shell_r[31], eta_shell_r};
    d_shell    = {eta_shell_r[31], eta_shell_r} - {eta_solvent_r[31], eta_solvent_r};
  end

  // whole pipeline moves when the output register can take a result
  logic        out_valid_r;
  logic [63:0] out_amp_r;
  logic        out_sat_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // angle CORDIC chains
  cdc_t th_c [CORDIC_STAGES+1];
  cdc_t ph_c [CORDIC_STAGES+1];
  cdc_t th_prep_r;
  cdc_t ph_prep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_prep_r.vld <= 1'b0;
      ph_prep_r.vld <= 1'b0;
    end else if (en) begin
      th_prep_r <= cordic_prep(in_valid, {in_polar_angle, 16'h0000}, 64'd0);
      ph_prep_r <= cordic_prep(in_valid, {in_azimuth_angle, 16'h0000}, 64'd0);
    end
  end

  assign th_c[0] = th_prep_r;
  assign ph_c[0] = ph_prep_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_ang
    cff_cordic_cell u_th (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .idx  (5'(i)),
      .cin  (th_c[i]),
      .cout (th_c[i+1])
    );
    cff_cordic_cell u_ph (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .idx  (5'(i)),
      .cin  (ph_c[i]),
      .cout (ph_c[i+1])
    );
  end

  // trig products: |sin t cos p|, |sin t sin p|, |cos t|
  logic [CW-1:0]   st_m;
  logic [CW-1:0]   ct_m;
  logic [CW-1:0]   sp_m;
  logic [CW-1:0]   cp_m;
  logic [2*CW-1:0] pr0;
  logic [2*CW-1:0] pr1;
  logic            s1_vld_r;
  logic [31:0]     t_r [3];

  always_comb begin
    st_m = cmag(th_c[CORDIC_STAGES].y);
    ct_m = cmag(th_c[CORDIC_STAGES].x);
    sp_m = cmag(ph_c[CORDIC_STAGES].y);
    cp_m = cmag(ph_c[CORDIC_STAGES].x);
    pr0  = st_m * cp_m;
    pr1  = st_m * sp_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= th_c[CORDIC_STAGES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= pr0[61:30];
      t_r[1] <= pr1[61:30];
      t_r[2] <= ct_m[31:0];
    end
  end

  // q components, clamped to 32 bits
  logic        s2_vld_r;
  logic [31:0] qc_r [3];
  logic [63:0] qp [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qp[k] = q_magnitude_r * t_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        qc_r[k] <= (qp[k][63:62] != 2'b00) ? 32'hFFFF_FFFF : qp[k][61:30];
      end
    end
  end

  // sinc arguments for core (part 0) and shell (part 1)
  logic        s3_vld_r;
  logic [63:0] u_r [2][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_r[0][k] <= qc_r[k] * edge_core[32:1];
        u_r[1][k] <= qc_r[k] * edge_shell[32:1];
      end
    end
  end

  // six sinc units
  logic        snc_vld  [2][3];
  logic [30:0] snc_mag  [2][3];
  logic        snc_neg  [2][3];

  for (genvar p = 0; p < 2; p++) begin : g_part
    for (genvar k = 0; k < 3; k++) begin : g_axis
      cff_sinc u_sinc (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (s3_vld_r),
        .u_in   (u_r[p][k]),
        .out_vld(snc_vld[p][k]),
        .smag   (snc_mag[p][k]),
        .sneg   (snc_neg[p][k])
      );
    end
  end

  // amplitude chains: three sinc factors (bypassed when plain), then edge cubed
  amp_t        core_c  [7];
  amp_t        shell_c [7];
  logic [32:0] dmag_core;
  logic [32:0] dmag_shell;

  always_comb begin
    dmag_core  = d_core[32] ? 33'(-d_core) : 33'(d_core);
    dmag_shell = d_shell[32] ? 33'(-d_shell) : 33'(d_shell);

    core_c[0].vld  = snc_vld[0][0];
    core_c[0].neg  = d_core[32];
    core_c[0].sat  = 1'b0;
    core_c[0].a    = 64'({dmag_core, 16'h0000});
    shell_c[0].vld = snc_vld[1][0];
    shell_c[0].neg = d_shell[32];
    shell_c[0].sat = 1'b0;
    shell_c[0].a   = 64'({dmag_shell, 16'h0000});
    for (int k = 0; k < 3; k++) begin
      core_c[0].smag[k]  = snc_mag[0][k];
      core_c[0].sneg[k]  = snc_neg[0][k];
      shell_c[0].smag[k] = snc_mag[1][k];
      shell_c[0].sneg[k] = snc_neg[1][k];
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_amp
    if (k < 3) begin : g_sinc_mul
      cff_mul_cell u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ain   (core_c[k]),
        .b     ({2'b00, core_c[k].smag[k]}),
        .sh30  (1'b1),
        .bypass(plain),
        .bneg  (core_c[k].sneg[k]),
        .aout  (core_c[k+1])
      );
      cff_mul_cell u_shell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ain   (shell_c[k]),
        .b     ({2'b00, shell_c[k].smag[k]}),
        .sh30  (1'b1),
        .bypass(plain),
        .bneg  (shell_c[k].sneg[k]),
        .aout  (shell_c[k+1])
      );
    end else begin : g_edge_mul
      cff_mul_cell u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ain   (core_c[k]),
        .b     (edge_core),
        .sh30  (1'b0),
        .bypass(1'b0),
        .bneg  (1'b0),
        .aout  (core_c[k+1])
      );
      cff_mul_cell u_shell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ain   (shell_c[k]),
        .b     (edge_shell),
        .sh30  (1'b0),
        .bypass(1'b0),
        .bneg  (1'b0),
        .aout  (shell_c[k+1])
      );
    end
  end

  // signed sum of core and shell amplitudes in shell mode, else the core alone
  logic        cmb_vld_r;
  logic [63:0] cmb_m_r;
  logic        cmb_sat_r;
  logic [63:0] cmb_m;
  logic        cmb_sat;
  logic [64:0] msum;
  amp_t        ca;
  amp_t        sa;

  always_comb begin
    ca      = core_c[6];
    sa      = shell_c[6];
    msum    = {1'b0, ca.a} + {1'b0, sa.a};
    cmb_m   = ca.a;
    cmb_sat = ca.sat;
    if (shell_mode_r) begin
      cmb_sat = ca.sat | sa.sat;
      if (ca.neg == sa.neg) begin
        cmb_m   = msum[63:0];
        cmb_sat = cmb_sat | msum[64];
      end else if (ca.a >= sa.a) begin
        cmb_m = ca.a - sa.a;
      end else begin
        cmb_m = sa.a - ca.a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmb_vld_r <= 1'b0;
    end else if (en) begin
      cmb_vld_r <= ca.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmb_m_r   <= cmb_m;
      cmb_sat_r <= cmb_sat;
    end
  end

  // square: partial products, then sum and scale into the output register
  logic        sq_vld_r;
  logic        sq_sat_r;
  logic [63:0] p00_r;
  logic [63:0] p01_r;
  logic [63:0] p11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (en) begin
      sq_vld_r <= cmb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sat_r <= cmb_sat_r;
      p00_r    <= cmb_m_r[31:0] * cmb_m_r[31:0];
      p01_r    <= cmb_m_r[31:0] * cmb_m_r[63:32];
      p11_r    <= cmb_m_r[63:32] * cmb_m_r[63:32];
    end
  end

  logic [127:0] sq_full;
  logic         res_sat;
  logic [63:0]  res_amp;

  always_comb begin
    sq_full = {p11_r, 64'd0} + {31'd0, p01_r, 33'd0} + 128'(p00_r);
    res_sat = sq_sat_r || (sq_full[127:96] != '0);
    res_amp = res_sat ? 64'hFFFF_FFFF_FFFF_FFFF : sq_full[95:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_amp_r <= res_amp;
      out_sat_r <= res_sat;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_amplitude_squared = out_amp_r;
  assign out_saturated         = out_sat_r;

`ifndef SYNTHESIS
  // a flagged result is always the clipped maximum
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_amplitude_squared == 64'hFFFF_FFFF_FFFF_FFFF)
    else $error("saturated result not at maximum");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // core and shell chains stay in lockstep
  a_chain_lock: assert property (@(posedge clk) disable iff (!rst_n)
    core_c[6].vld == shell_c[6].vld)
    else $error("amplitude chains out of step");

  // the first sinc unit's magnitude never exceeds one
  a_sinc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    snc_vld[0][0] |-> snc_mag[0][0] <= ONE_Q30)
    else $error("sinc magnitude above one");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top
  import cff_pkg::*;
();

  typedef struct {
    logic [63:0] amp;
    logic        sat;
  } cube_result_t;

  // holds the register image and the queue of predicted amplitudes
  class cff_scoreboard;
    logic [31:0]  regs [8];
    cube_result_t pending[$];
    int           errors;
    longint       atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                   21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                   333772, 166886, 83443, 41722, 20861};

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      if (idx == CFG_SHELL_MODE) regs[idx] = {31'd0, data[0]};
      else regs[idx] = data;
    endfunction

    // rotation-mode CORDIC on a quantized turn phase
    function void rotate(input logic [31:0] ph, output longint sn, output longint cs);
      logic [31:0] p;
      logic [31:0] probe;
      logic        flip;
      longint      x, y, z, nx;
      p = ph & ANGLE_MASK;
      probe = p + 32'h4000_0000;
      flip = probe[31];
      if (flip) p = p - 32'h8000_0000;
      z = longint'($signed(p));
      x = 652032875;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // 64x64 product shifted right, saturating on overflow
    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh, inout logic sat);
      logic [127:0] pr;
      pr = 128'(a) * 128'(b);
      if ((pr >> (64 + sh)) != 0) begin
        sat = 1'b1;
        return '1;
      end
      return 64'(pr >> sh);
    endfunction

    // Q1.30 sinc of a Q32.32 argument
    function longint sinc_q30(logic [63:0] u);
      logic [63:0]  uq, hi, lo;
      logic [31:0]  phase;
      logic [127:0] qt;
      longint       s, c;
      if (u < 64'h1000_0000) begin
        uq = u >> 2;
        return 64'sd1073741824 - longint'(((uq * uq) >> 30) / 6);
      end
      hi = u >> 32;
      lo = u & 64'hFFFF_FFFF;
      phase = 32'(hi * 64'd683565276) + 32'((lo * 64'd683565276) >> 32);
      rotate(phase, s, c);
      qt = (128'(mag(s)) << 32) / 128'(u);
      if (qt > 128'd1073741824) qt = 128'd1073741824;
      return s < 0 ? -longint'(qt) : longint'(qt);
    endfunction

    function logic [63:0] q_comp(logic [63:0] q, longint a, longint b);
      logic [63:0] t, r;
      t = (mag(a) * mag(b)) >> 30;
      r = (q * t) >> 30;
      return r > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : r;
    endfunction

    // one cube: density step times volume times the three sinc terms unless plain
    function void cube_amp(input longint d, input logic [63:0] len, input logic [63:0] qc[3],
                           input logic plain, output logic [63:0] m, output logic neg,
                           inout logic sat);
      logic [63:0] a;
      longint      s;
      a = mag(d) << 16;
      neg = d < 0;
      if (!plain) begin
        for (int k = 0; k < 3; k++) begin
          s = sinc_q30(qc[k] * (len >> 1));
          if (s < 0) neg = !neg;
          a = mul_shift(a, mag(s), 30, sat);
        end
      end
      for (int k = 0; k < 3; k++) a = mul_shift(a, len, 16, sat);
      m = a;
    endfunction

    function void note_request(logic [15:0] polar, logic [15:0] azim);
      longint       st, ct, sp, cp, ecore, eshell, esolv;
      logic [63:0]  qc[3], q, m, m2, sum;
      logic         n, n2, sat, plain;
      cube_result_t r;
      q = 64'(regs[CFG_Q_MAGNITUDE]);
      plain = regs[CFG_Q_MAGNITUDE] < regs[CFG_Q_THRESHOLD];
      ecore = longint'($signed(regs[CFG_ETA_CORE]));
      eshell = longint'($signed(regs[CFG_ETA_SHELL]));
      esolv = longint'($signed(regs[CFG_ETA_SOLVENT]));
      sat = 1'b0;
      rotate({polar, 16'd0}, st, ct);
      rotate({azim, 16'd0}, sp, cp);
      qc[0] = q_comp(q, st, cp);
      qc[1] = q_comp(q, st, sp);
      qc[2] = (q * mag(ct)) >> 30;
      if (qc[2] > 64'hFFFF_FFFF) qc[2] = 64'hFFFF_FFFF;
      cube_amp(ecore - eshell, 64'(regs[CFG_CORE_EDGE]), qc, plain, m, n, sat);
      if (regs[CFG_SHELL_MODE][0]) begin
        cube_amp(eshell - esolv, 64'(regs[CFG_CORE_EDGE]) + 64'(regs[CFG_SHELL_THICKNESS]),
                 qc, plain, m2, n2, sat);
        if (n == n2) begin
          sum = m + m2;
          if (sum < m) sat = 1'b1;
          m = sum;
        end else if (m >= m2) begin
          m = m - m2;
        end else begin
          m = m2 - m;
        end
      end
      if (!sat) m = mul_shift(m, m, 32, sat);
      r.amp = sat ? '1 : m;
      r.sat = sat;
      pending.push_back(r);
    endfunction

    task check_result(logic [63:0] amp, logic sat);
      cube_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result amp=%h sat=%b", amp, sat));
        return;
      end
      e = pending.pop_front();
      if (amp !== e.amp) report($sformatf("amplitude got %h exp %h", amp, e.amp));
      if (sat !== e.sat) report($sformatf("saturated got %b exp %b", sat, e.sat));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_polar_angle;
  logic [15:0] in_azimuth_angle;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_amplitude_squared;
  logic        out_saturated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  cff_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  cube_form_factor_squared DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watch all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.note_request(in_polar_angle, in_azimuth_angle);
      if (out_valid && out_ready) sb.check_result(out_amplitude_squared, out_saturated);
    end
  end

  task cfg_write(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task write_all(logic [31:0] thr, logic [31:0] q, logic [31:0] ec, logic [31:0] es,
                 logic [31:0] eso, logic [31:0] len, logic [31:0] thk, logic [31:0] mode);
    cfg_write(CFG_Q_THRESHOLD, thr);
    cfg_write(CFG_Q_MAGNITUDE, q);
    cfg_write(CFG_ETA_CORE, ec);
    cfg_write(CFG_ETA_SHELL, es);
    cfg_write(CFG_ETA_SOLVENT, eso);
    cfg_write(CFG_CORE_EDGE, len);
    cfg_write(CFG_SHELL_THICKNESS, thk);
    cfg_write(CFG_SHELL_MODE, mode);
  endtask

  // one request; valid stays up until accepted
  task send_request(logic [15:0] polar, logic [15:0] azim);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_polar_angle <= polar;
    in_azimuth_angle <= azim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait for every predicted result
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function logic [31:0] rand_eta();
    int v;
    if ($urandom_range(0, 3) == 0) return $urandom;
    v = int'($urandom_range(0, 32'h40000)) - 32'h20000;
    return 32'(v);
  endfunction

  function logic [31:0] rand_len();
    return ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
  endfunction

  task random_config();
    logic [31:0] thr;
    logic [31:0] q;
    q = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 32'h000A_0000);
    case ($urandom_range(0, 3))
      0: thr = 32'd0;
      1: thr = 32'hFFFF_FFFF;
      default: thr = $urandom_range(0, 32'h0002_0000);
    endcase
    write_all(thr, q, rand_eta(), rand_eta(), rand_eta(), rand_len(), rand_len(), $urandom);
  endtask

  logic [15:0] dir_pol[12] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                               16'h0000, 16'hAAAA, 16'h5555, 16'h0001, 16'h3FFF, 16'hE000};
  logic [15:0] dir_az[12]  = '{16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 16'h8000, 16'h6000,
                               16'hC000, 16'h5555, 16'hAAAA, 16'hFFFE, 16'h4001, 16'h1000};

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_polar_angle = '0;
    in_azimuth_angle = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain cube with modulation on
    write_all(32'd0, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 32'h0004_0000,
              32'h0001_0000, 32'd0);
    foreach (dir_pol[i]) send_request(dir_pol[i], dir_az[i]);
    drain();
    // threshold above q: no sinc terms; shell edge carries past 32 bits
    write_all(32'hFFFF_FFFF, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h7FFF_FFFF,
              32'hF000_0000, 32'h2000_0000, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_request(dir_pol[i], dir_az[i]);
    drain();
    // saturating extremes, mode data with only high bits set
    write_all(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    for (int i = 0; i < 4; i++) send_request(dir_pol[i], dir_az[i]);
    drain();
    // zero q: small-argument sinc everywhere, core-shell sum
    write_all(32'd0, 32'd0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_1000, 32'h0002_0000,
              32'h0000_8000, 32'd1);
    for (int i = 4; i < 8; i++) send_request(dir_pol[i], dir_az[i]);
    drain();

    // random phases across idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      random_config();
      if (ph == 4) hold_cycles = 300;
      for (int n = 0; n < 92; n++) begin
        if (ph == 5 && n == 46) drain();
        send_request(16'($urandom), 16'($urandom));
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* cube_form_factor_squared.f */
src/cff_pkg.sv
src/cff_cordic_cell.sv
src/cff_div_cell.sv
src/cff_sinc.sv
src/cff_mul_cell.sv
src/cube_form_factor_squared.sv
tb/sv/tb_top.sv
